FILE: src/tbe_pkg.sv
// Shared types and constants of the tetrahedron barycentric embedding unit.
package tbe_pkg;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_FETCH,
        ST_DIFF,
        ST_MUL,
        ST_ACC,
        ST_DIV_PRE,
        ST_DIV,
        ST_FINISH
    } t_state;

    // Command codes carried on the input tuser.
    typedef enum logic [2:0] {
        CMD_WR_REST  = 3'd0,
        CMD_WR_LIVE  = 3'd1,
        CMD_TET_BARY = 3'd2,
        CMD_TET_LIVE = 3'd3,
        CMD_TRI_REST = 3'd4,
        CMD_TRI_LIVE = 3'd5
    } t_cmd;

    // Status codes carried on the output tuser.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DEGEN = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    // Edge vector slots of the tetrahedron.
    localparam logic [2:0] DI_AP = 3'd0;
    localparam logic [2:0] DI_BP = 3'd1;
    localparam logic [2:0] DI_AB = 3'd2;
    localparam logic [2:0] DI_AC = 3'd3;
    localparam logic [2:0] DI_AD = 3'd4;
    localparam logic [2:0] DI_BC = 3'd5;
    localparam logic [2:0] DI_BD = 3'd6;

    // Triple product sequence: denominator first, then the four numerators.
    localparam logic [2:0] TRI_DEN  = 3'd0;
    localparam logic [2:0] TRI_LAST = 3'd4;

    // Steps of one triple product: six cross terms, then six dot halves.
    localparam logic [3:0] STEP_DOT  = 4'd6;
    localparam logic [3:0] STEP_LAST = 4'd11;

    // Datapath widths.
    localparam int IDX_W = 12;
    localparam int CRD_W = 32;
    localparam int DIF_W = 33;
    localparam int CR_W  = 67;
    localparam int MOP_W = 35;
    localparam int PRD_W = 70;
    localparam int ACC_W = 104;
    localparam int REM_W = 128;
    localparam int DSH_W = 137;
    localparam int IN_W  = 272;
    localparam int OUT_W = 224;

endpackage

FILE: src/tbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tbe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: src/tet_barycentric_embed_unit.sv
// Top level of the tetrahedron barycentric embedding unit.
//
// Items enter on the slave stream: tuser holds the command, tdata the corner
// indices, the point and the blend weights. Every item gives exactly one item
// on the master stream: tuser holds the status, tdata the blended position
// and the four barycentric weights.
// Vertex writes go to a rest RAM or a live RAM of VERTEX_COUNT entries each,
// both 96 bits wide with one read port; read data is registered and returns in the next cycle.
// From one accepted item to the next with the receiver ready: a vertex write
// passes through the write and finish states, an unknown command through finish
// only. Blends fetch n = 3 or 4 vertices, then run 3*n multiply-accumulate steps,
// each a multiply and an accumulate state, on the shared 35x35 multiplier. A
// tetrahedron query fetches 4 vertices, runs five triple products and four restoring
// divisions (one quotient bit a cycle, skipped when the quotient surely saturates);
// it stops after the denominator when the tetrahedron is degenerate.
// One item is worked on at a time; tready is high only while idle.
// The result sits in an output register, so the next item is accepted while
// the receiver stalls; a further result waits until that register is taken.
// Reset clears the sequencer and the output valid; RAM contents are kept and
// are undefined until written.
module tet_barycentric_embed_unit #(
    parameter int VERTEX_COUNT = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // corner_a, corner_b, corner_c, corner_d, point_x, point_y, point_z,
    // weight_a, weight_b, weight_c, weight_d
    input  logic [271:0] i_s_axis_tdata,
    // command
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pos_x, pos_y, pos_z, bary_a, bary_b, bary_c, bary_d
    output logic [223:0] o_m_axis_tdata,
    // status
    output logic [1:0]   o_m_axis_tuser
);

    localparam int ADDR_W = $clog2(VERTEX_COUNT);
    localparam int VTX_W  = 3 * tbe_pkg::CRD_W;
    localparam logic signed [tbe_pkg::ACC_W-1:0] MAX32 = 104'sh7FFF_FFFF;
    localparam logic signed [tbe_pkg::ACC_W-1:0] MIN32 = -104'sh8000_0000;
    localparam logic signed [tbe_pkg::ACC_W-1:0] HALF_LSB = 104'sh80_0000;

    // Reduce a vertex index modulo the store depth by restoring subtraction.
    function automatic logic [ADDR_W-1:0] vidx(input logic [tbe_pkg::IDX_W-1:0] idx);
        logic [16:0] r;
        r = {5'd0, idx};
        for (int k = tbe_pkg::IDX_W - 1; k >= 0; k--) begin
            if ((VERTEX_COUNT << k) <= int'(r)) begin
                r = r - 17'(VERTEX_COUNT << k);
            end
        end
        return r[ADDR_W-1:0];
    endfunction

    // Clamp to the signed 32-bit range; the top bit flags saturation.
    function automatic logic [32:0] sat32(input logic signed [tbe_pkg::ACC_W-1:0] v);
        logic [32:0] res;
        if (v > MAX32) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < MIN32) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    tbe_pkg::t_state r_state, n_state;

    logic [2:0]                        r_cmd;
    logic [tbe_pkg::IDX_W-1:0]         r_idx  [4];
    logic signed [tbe_pkg::CRD_W-1:0]  r_p    [3];
    logic signed [tbe_pkg::CRD_W-1:0]  r_w    [4];
    logic signed [tbe_pkg::CRD_W-1:0]  r_v    [4][3];
    logic signed [tbe_pkg::DIF_W-1:0]  r_dif  [7][3];
    logic signed [tbe_pkg::CR_W-1:0]   r_cr   [3];
    logic signed [tbe_pkg::ACC_W-1:0]  r_acc;
    logic [tbe_pkg::ACC_W-1:0]         r_dabs;
    logic                              r_dneg;
    logic signed [tbe_pkg::PRD_W-1:0]  r_prod;
    logic [2:0]                        r_fcnt;
    logic [2:0]                        r_tri;
    logic [3:0]                        r_step;
    logic [1:0]                        r_j, r_k;
    logic [tbe_pkg::REM_W-1:0]         r_rem;
    logic [tbe_pkg::DSH_W-1:0]         r_dsh;
    logic [32:0]                       r_q;
    logic [5:0]                        r_qcnt;
    logic                              r_neg;
    logic                              r_sat, r_degen;
    logic signed [tbe_pkg::CRD_W-1:0]  r_pos  [3];
    logic signed [tbe_pkg::CRD_W-1:0]  r_bary [4];
    logic                              r_m_valid;
    logic [tbe_pkg::OUT_W-1:0]         r_m_data;
    logic [1:0]                        r_m_user;

    logic                              w_accept, w_room, w_out_load;
    logic                              w_rest_we, w_live_we;
    logic                              w_bary, w_live;
    logic [2:0]                        w_n;
    logic [tbe_pkg::IDX_W-1:0]         w_fidx;
    logic [ADDR_W-1:0]                 w_raddr, w_waddr;
    logic [VTX_W-1:0]                  w_wdata, w_rest_rd, w_live_rd, w_rd;
    logic signed [tbe_pkg::DIF_W-1:0]  w_u [3], w_tv [3], w_tw [3];
    logic [1:0]                        w_cj, w_j1, w_j2, w_dj;
    logic [3:0]                        w_doff;
    logic signed [tbe_pkg::MOP_W-1:0]  w_ma, w_mb;
    logic signed [tbe_pkg::ACC_W-1:0]  w_base, w_add, w_acc_new;
    logic [32:0]                       w_pos_sat;
    logic                              w_blend_last;
    logic [tbe_pkg::ACC_W-1:0]         w_nabs;
    logic                              w_pre_sat;
    logic                              w_qbit;
    logic [32:0]                       w_qfin;
    logic [32:0]                       w_div_res;
    logic [1:0]                        w_bsel;

    // Command decode of the item in work.
    assign w_bary = (r_cmd == tbe_pkg::CMD_TET_BARY);
    assign w_live = (r_cmd == tbe_pkg::CMD_TET_LIVE) || (r_cmd == tbe_pkg::CMD_TRI_LIVE);
    assign w_n    = ((r_cmd == tbe_pkg::CMD_TET_BARY) || (r_cmd == tbe_pkg::CMD_TET_LIVE))
                    ? 3'd4 : 3'd3;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_room   = !r_m_valid || i_m_axis_tready;
    assign w_bsel   = 2'(r_tri - 3'd1);

    // Vertex fetch order: triangles read b, c, a so weights line up.
    always_comb begin
        w_fidx = r_idx[0];
        if ((r_cmd == tbe_pkg::CMD_TRI_REST) || (r_cmd == tbe_pkg::CMD_TRI_LIVE)) begin
            case (r_fcnt[1:0])
                2'd0:    w_fidx = r_idx[1];
                2'd1:    w_fidx = r_idx[2];
                default: w_fidx = r_idx[0];
            endcase
        end else begin
            w_fidx = r_idx[r_fcnt[1:0]];
        end
    end

    assign w_raddr = vidx(w_fidx);
    assign w_waddr = vidx(r_idx[0]);
    assign w_wdata = {r_p[2], r_p[1], r_p[0]};
    assign w_rd    = w_live ? w_live_rd : w_rest_rd;

    tbe_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_COUNT)) u_rest_ram (
        .i_clk   (i_clk),
        .i_we    (w_rest_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rest_rd)
    );

    tbe_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_COUNT)) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (w_live_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_live_rd)
    );

    // Edge vectors of the triple product in work.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            case (r_tri)
                3'd1: begin
                    w_u[j] = r_dif[tbe_pkg::DI_BP][j];
                    w_tv[j] = r_dif[tbe_pkg::DI_BD][j];
                    w_tw[j] = r_dif[tbe_pkg::DI_BC][j];
                end
                3'd2: begin
                    w_u[j] = r_dif[tbe_pkg::DI_AP][j];
                    w_tv[j] = r_dif[tbe_pkg::DI_AC][j];
                    w_tw[j] = r_dif[tbe_pkg::DI_AD][j];
                end
                3'd3: begin
                    w_u[j] = r_dif[tbe_pkg::DI_AP][j];
                    w_tv[j] = r_dif[tbe_pkg::DI_AD][j];
                    w_tw[j] = r_dif[tbe_pkg::DI_AB][j];
                end
                3'd4: begin
                    w_u[j] = r_dif[tbe_pkg::DI_AP][j];
                    w_tv[j] = r_dif[tbe_pkg::DI_AB][j];
                    w_tw[j] = r_dif[tbe_pkg::DI_AC][j];
                end
                default: begin
                    w_u[j] = r_dif[tbe_pkg::DI_AB][j];
                    w_tv[j] = r_dif[tbe_pkg::DI_AC][j];
                    w_tw[j] = r_dif[tbe_pkg::DI_AD][j];
                end
            endcase
        end
    end

    // Component indices for the cross and dot steps.
    assign w_cj   = r_step[2:1];
    assign w_doff = 4'(r_step - tbe_pkg::STEP_DOT);
    assign w_dj   = w_doff[2:1];

    always_comb begin
        case (w_cj)
            2'd0: begin
                w_j1 = 2'd1;
                w_j2 = 2'd2;
            end
            2'd1: begin
                w_j1 = 2'd2;
                w_j2 = 2'd0;
            end
            default: begin
                w_j1 = 2'd0;
                w_j2 = 2'd1;
            end
        endcase
    end

    // Multiplier operand selection.
    always_comb begin
        if (w_bary) begin
            if (r_step < tbe_pkg::STEP_DOT) begin
                if (!r_step[0]) begin
                    w_ma = tbe_pkg::MOP_W'(w_tv[w_j1]);
                    w_mb = tbe_pkg::MOP_W'(w_tw[w_j2]);
                end else begin
                    w_ma = tbe_pkg::MOP_W'(w_tv[w_j2]);
                    w_mb = tbe_pkg::MOP_W'(w_tw[w_j1]);
                end
            end else begin
                w_ma = tbe_pkg::MOP_W'(w_u[w_dj]);
                if (w_doff[0]) begin
                    w_mb = tbe_pkg::MOP_W'($signed(r_cr[w_dj][66:34]));
                end else begin
                    w_mb = $signed({1'b0, r_cr[w_dj][33:0]});
                end
            end
        end else begin
            w_ma = tbe_pkg::MOP_W'(r_w[r_k]);
            w_mb = tbe_pkg::MOP_W'(r_v[r_k][r_j]);
        end
    end

    // Accumulator update.
    always_comb begin
        if (w_bary) begin
            w_base = (r_step == tbe_pkg::STEP_DOT) ? '0 : r_acc;
            if (w_doff[0]) begin
                w_add = tbe_pkg::ACC_W'(r_prod) <<< 34;
            end else begin
                w_add = tbe_pkg::ACC_W'(r_prod);
            end
        end else begin
            w_base = (r_k == 2'd0) ? HALF_LSB : r_acc;
            w_add  = tbe_pkg::ACC_W'(r_prod);
        end
        w_acc_new = w_base + w_add;
    end

    assign w_pos_sat    = sat32(w_acc_new >>> 24);
    assign w_blend_last = ({1'b0, r_k} == (w_n - 3'd1));

    // Division setup and quotient bits.
    assign w_nabs    = r_acc[tbe_pkg::ACC_W-1] ? tbe_pkg::ACC_W'(-r_acc)
                                                : tbe_pkg::ACC_W'(r_acc);
    assign w_pre_sat = ((138'(w_nabs) << 24) >= (138'(r_dabs) << 33));
    assign w_qbit    = ({{(tbe_pkg::DSH_W - tbe_pkg::REM_W){1'b0}}, r_rem} >= r_dsh);
    assign w_qfin    = {r_q[31:0], w_qbit};

    always_comb begin
        if (r_neg) begin
            if (w_qfin > 33'h0_8000_0000) begin
                w_div_res = {1'b1, 32'h8000_0000};
            end else begin
                w_div_res = {1'b0, 32'(-w_qfin[31:0])};
            end
        end else begin
            if (w_qfin[32] || w_qfin[31]) begin
                w_div_res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                w_div_res = {1'b0, w_qfin[31:0]};
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbe_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    case (i_s_axis_tuser)
                        tbe_pkg::CMD_WR_REST, tbe_pkg::CMD_WR_LIVE: n_state = tbe_pkg::ST_WRITE;
                        tbe_pkg::CMD_TET_BARY, tbe_pkg::CMD_TET_LIVE,
                        tbe_pkg::CMD_TRI_REST, tbe_pkg::CMD_TRI_LIVE: n_state = tbe_pkg::ST_FETCH;
                        default: n_state = tbe_pkg::ST_FINISH;
                    endcase
                end
            end
            tbe_pkg::ST_WRITE: n_state = tbe_pkg::ST_FINISH;
            tbe_pkg::ST_FETCH: begin
                if (r_fcnt == w_n) begin
                    n_state = w_bary ? tbe_pkg::ST_DIFF : tbe_pkg::ST_MUL;
                end
            end
            tbe_pkg::ST_DIFF: n_state = tbe_pkg::ST_MUL;
            tbe_pkg::ST_MUL:  n_state = tbe_pkg::ST_ACC;
            tbe_pkg::ST_ACC: begin
                if (w_bary) begin
                    if (r_step == tbe_pkg::STEP_LAST) begin
                        if (r_tri == tbe_pkg::TRI_DEN) begin
                            n_state = (w_acc_new == '0) ? tbe_pkg::ST_FINISH : tbe_pkg::ST_MUL;
                        end else begin
                            n_state = tbe_pkg::ST_DIV_PRE;
                        end
                    end else begin
                        n_state = tbe_pkg::ST_MUL;
                    end
                end else begin
                    n_state = (w_blend_last && (r_j == 2'd2)) ? tbe_pkg::ST_FINISH
                                                              : tbe_pkg::ST_MUL;
                end
            end
            tbe_pkg::ST_DIV_PRE: begin
                if (w_pre_sat) begin
                    n_state = (r_tri == tbe_pkg::TRI_LAST) ? tbe_pkg::ST_FINISH
                                                           : tbe_pkg::ST_MUL;
                end else begin
                    n_state = tbe_pkg::ST_DIV;
                end
            end
            tbe_pkg::ST_DIV: begin
                if (r_qcnt == 6'd0) begin
                    n_state = (r_tri == tbe_pkg::TRI_LAST) ? tbe_pkg::ST_FINISH
                                                           : tbe_pkg::ST_MUL;
                end
            end
            tbe_pkg::ST_FINISH: begin
                if (w_room) begin
                    n_state = tbe_pkg::ST_IDLE;
                end
            end
            default: n_state = tbe_pkg::ST_IDLE;
        endcase
    end

    // State-driven controls.
    always_comb begin
        o_s_axis_tready = (r_state == tbe_pkg::ST_IDLE);
        w_rest_we  = (r_state == tbe_pkg::ST_WRITE) && (r_cmd == tbe_pkg::CMD_WR_REST);
        w_live_we  = (r_state == tbe_pkg::ST_WRITE) && (r_cmd == tbe_pkg::CMD_WR_LIVE);
        w_out_load = (r_state == tbe_pkg::ST_FINISH) && w_room;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tbe_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tbe_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_cmd <= i_s_axis_tuser;
                    for (int k = 0; k < 4; k++) begin
                        r_idx[k]  <= i_s_axis_tdata[k*12 +: 12];
                        r_w[k]    <= $signed(i_s_axis_tdata[144 + k*32 +: 32]);
                        r_bary[k] <= '0;
                    end
                    for (int j = 0; j < 3; j++) begin
                        r_p[j]   <= $signed(i_s_axis_tdata[48 + j*32 +: 32]);
                        r_pos[j] <= '0;
                    end
                    r_sat   <= 1'b0;
                    r_degen <= 1'b0;
                    r_fcnt  <= '0;
                    r_tri   <= tbe_pkg::TRI_DEN;
                    r_step  <= '0;
                    r_j     <= '0;
                    r_k     <= '0;
                end
            end
            tbe_pkg::ST_FETCH: begin
                // Data of the previous read arrives in the cycle after its address.
                if (r_fcnt != 3'd0) begin
                    for (int j = 0; j < 3; j++) begin
                        r_v[2'(r_fcnt - 3'd1)][j] <= $signed(w_rd[j*32 +: 32]);
                    end
                end
                r_fcnt <= r_fcnt + 3'd1;
            end
            tbe_pkg::ST_DIFF: begin
                for (int j = 0; j < 3; j++) begin
                    r_dif[tbe_pkg::DI_AP][j] <= 33'(r_p[j]) - 33'(r_v[0][j]);
                    r_dif[tbe_pkg::DI_BP][j] <= 33'(r_p[j]) - 33'(r_v[1][j]);
                    r_dif[tbe_pkg::DI_AB][j] <= 33'(r_v[1][j]) - 33'(r_v[0][j]);
                    r_dif[tbe_pkg::DI_AC][j] <= 33'(r_v[2][j]) - 33'(r_v[0][j]);
                    r_dif[tbe_pkg::DI_AD][j] <= 33'(r_v[3][j]) - 33'(r_v[0][j]);
                    r_dif[tbe_pkg::DI_BC][j] <= 33'(r_v[2][j]) - 33'(r_v[1][j]);
                    r_dif[tbe_pkg::DI_BD][j] <= 33'(r_v[3][j]) - 33'(r_v[1][j]);
                end
            end
            tbe_pkg::ST_MUL: begin
                r_prod <= w_ma * w_mb;
            end
            tbe_pkg::ST_ACC: begin
                if (w_bary) begin
                    if (r_step < tbe_pkg::STEP_DOT) begin
                        // Cross product terms: first one loads, second one subtracts.
                        if (!r_step[0]) begin
                            r_cr[w_cj] <= r_prod[tbe_pkg::CR_W-1:0];
                        end else begin
                            r_cr[w_cj] <= r_cr[w_cj] - r_prod[tbe_pkg::CR_W-1:0];
                        end
                    end else begin
                        r_acc <= w_acc_new;
                    end
                    if (r_step == tbe_pkg::STEP_LAST) begin
                        r_step <= '0;
                        if (r_tri == tbe_pkg::TRI_DEN) begin
                            r_dneg  <= w_acc_new[tbe_pkg::ACC_W-1];
                            r_dabs  <= w_acc_new[tbe_pkg::ACC_W-1]
                                       ? tbe_pkg::ACC_W'(-w_acc_new)
                                       : tbe_pkg::ACC_W'(w_acc_new);
                            r_degen <= (w_acc_new == '0);
                            r_tri   <= r_tri + 3'd1;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end else begin
                    r_acc <= w_acc_new;
                    if (w_blend_last) begin
                        r_pos[r_j] <= $signed(w_pos_sat[31:0]);
                        if (w_pos_sat[32]) begin
                            r_sat <= 1'b1;
                        end
                        r_k <= '0;
                        r_j <= r_j + 2'd1;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
            end
            tbe_pkg::ST_DIV_PRE: begin
                r_rem  <= tbe_pkg::REM_W'(w_nabs) << 24;
                r_dsh  <= tbe_pkg::DSH_W'(r_dabs) << 32;
                r_neg  <= r_acc[tbe_pkg::ACC_W-1] ^ r_dneg;
                r_q    <= '0;
                r_qcnt <= 6'd32;
                if (w_pre_sat) begin
                    r_bary[w_bsel] <= (r_acc[tbe_pkg::ACC_W-1] ^ r_dneg)
                                      ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    r_sat <= 1'b1;
                    r_tri <= r_tri + 3'd1;
                end
            end
            tbe_pkg::ST_DIV: begin
                // One restoring step per cycle, divisor walks down one bit.
                if (w_qbit) begin
                    r_rem <= r_rem - r_dsh[tbe_pkg::REM_W-1:0];
                end
                r_dsh  <= r_dsh >> 1;
                r_q    <= w_qfin;
                r_qcnt <= r_qcnt - 6'd1;
                if (r_qcnt == 6'd0) begin
                    r_bary[w_bsel] <= $signed(w_div_res[31:0]);
                    if (w_div_res[32]) begin
                        r_sat <= 1'b1;
                    end
                    r_tri <= r_tri + 3'd1;
                end
            end
            default: begin
            end
        endcase

        // Output register.
        if (w_out_load) begin
            r_m_data <= {r_bary[3], r_bary[2], r_bary[1], r_bary[0],
                         r_pos[2], r_pos[1], r_pos[0]};
            if (r_degen) begin
                r_m_user <= tbe_pkg::STAT_DEGEN;
            end else if (r_sat) begin
                r_m_user <= tbe_pkg::STAT_SAT;
            end else begin
                r_m_user <= tbe_pkg::STAT_OK;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule

FILE: src/tbe_checker.sv
// Port-level checks of the tetrahedron barycentric embedding unit, bound to the top.
module tbe_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [271:0] i_s_axis_tdata,
    input logic [2:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [223:0] o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Status is always one of the defined codes.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == tbe_pkg::STAT_OK) ||
                            (o_m_axis_tuser == tbe_pkg::STAT_DEGEN) ||
                            (o_m_axis_tuser == tbe_pkg::STAT_SAT))
        else $error("undefined status code");

    // A degenerate tetrahedron gives all-zero data.
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == tbe_pkg::STAT_DEGEN) |-> (o_m_axis_tdata == '0))
        else $error("degenerate result carries data");

    // In the cycle after an accepted item the unit is not ready.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("item accepted back to back");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind tet_barycentric_embed_unit tbe_checker u_tbe_checker (.*);

FILE: bench/tb_tet_barycentric_embed_unit.sv
// Self-checking testbench of the tetrahedron barycentric embedding unit.
`timescale 1ns / 100ps

module tb_tet_barycentric_embed_unit;

    localparam int          CLK_HALF     = 6;
    localparam int          IDLE_LIMIT   = 4000;
    localparam int          RANDOM_ITEMS = 1850;
    localparam int          STORE_DEPTH  = 4096;
    localparam logic [2:0]  CMD_SPARE6   = 3'd6;
    localparam logic [2:0]  CMD_SPARE7   = 3'd7;

    typedef logic signed [127:0] wide_t;
    typedef wide_t vec3_t [3];

    // One input item, with an optional hand-typed status (all data zero).
    typedef struct {
        logic [2:0]  cmd;
        logic [11:0] corner [4];
        logic [31:0] point [3];
        logic [31:0] weight [4];
        bit          typed;
        logic [1:0]  typed_status;
    } query_t;

    typedef struct {
        logic [1:0]   status;
        logic [223:0] data;
    } answer_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [271:0] s_data = '0;
    logic [2:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [223:0] m_data;
    logic [1:0]   m_user;

    tet_barycentric_embed_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    // Shadow copies of the vertex stores and the lists of written entries.
    int          rest_pos [STORE_DEPTH][3];
    int          live_pos [STORE_DEPTH][3];
    logic [11:0] rest_written [$];
    logic [11:0] live_written [$];

    query_t      directed [$];
    answer_t     pending [$];
    int          errors = 0;
    bit          stim_done = 1'b0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Scalar triple product a . (b x c), exact.
    function automatic wide_t triple(input vec3_t a, input vec3_t b, input vec3_t c);
        wide_t cx, cy, cz;
        cx = b[1] * c[2] - b[2] * c[1];
        cy = b[2] * c[0] - b[0] * c[2];
        cz = b[0] * c[1] - b[1] * c[0];
        return a[0] * cx + a[1] * cy + a[2] * cz;
    endfunction

    // Clamp to the signed 32-bit range and flag saturation.
    function automatic logic [31:0] clamp32(input wide_t v, inout bit sat);
        if (v > 128'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sh8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic vec3_t fetch_vertex(input bit live, input logic [11:0] idx);
        vec3_t v;
        for (int j = 0; j < 3; j++) v[j] = live ? live_pos[idx][j] : rest_pos[idx][j];
        return v;
    endfunction

    // Predict the result of one accepted item and update the shadow stores.
    function automatic answer_t predict_embed(input query_t q);
        answer_t r;
        bit      sat;
        vec3_t   v [4];
        vec3_t   ap, bp, ab, ac, ad, bc, bd;
        wide_t   den, num [4], s, wt;
        logic [11:0] idx [4];
        int      n;
        bit      live;
        r.status = tbe_pkg::STAT_OK;
        r.data = '0;
        sat = 1'b0;
        case (q.cmd)
            tbe_pkg::CMD_WR_REST, tbe_pkg::CMD_WR_LIVE: begin
                for (int j = 0; j < 3; j++) begin
                    if (q.cmd == tbe_pkg::CMD_WR_REST) rest_pos[q.corner[0]][j] = q.point[j];
                    else live_pos[q.corner[0]][j] = q.point[j];
                end
            end
            tbe_pkg::CMD_TET_BARY: begin
                for (int k = 0; k < 4; k++) v[k] = fetch_vertex(1'b0, q.corner[k]);
                for (int j = 0; j < 3; j++) begin
                    ap[j] = $signed(q.point[j]) - v[0][j];
                    bp[j] = $signed(q.point[j]) - v[1][j];
                    ab[j] = v[1][j] - v[0][j];
                    ac[j] = v[2][j] - v[0][j];
                    ad[j] = v[3][j] - v[0][j];
                    bc[j] = v[2][j] - v[1][j];
                    bd[j] = v[3][j] - v[1][j];
                end
                den = triple(ab, ac, ad);
                if (den == 0) begin
                    r.status = tbe_pkg::STAT_DEGEN;
                end else begin
                    num[0] = triple(bp, bd, bc);
                    num[1] = triple(ap, ac, ad);
                    num[2] = triple(ap, ad, ab);
                    num[3] = triple(ap, ab, ac);
                    for (int k = 0; k < 4; k++)
                        r.data[96 + 32*k +: 32] = clamp32((num[k] <<< 24) / den, sat);
                    if (sat) r.status = tbe_pkg::STAT_SAT;
                end
            end
            tbe_pkg::CMD_TET_LIVE, tbe_pkg::CMD_TRI_REST, tbe_pkg::CMD_TRI_LIVE: begin
                live = (q.cmd != tbe_pkg::CMD_TRI_REST);
                if (q.cmd == tbe_pkg::CMD_TET_LIVE) begin
                    n = 4;
                    for (int k = 0; k < 4; k++) idx[k] = q.corner[k];
                end else begin
                    // Triangle weights a, b, c go to corners b, c, a.
                    n = 3;
                    idx[0] = q.corner[1];
                    idx[1] = q.corner[2];
                    idx[2] = q.corner[0];
                    idx[3] = '0;
                end
                for (int k = 0; k < n; k++) v[k] = fetch_vertex(live, idx[k]);
                for (int j = 0; j < 3; j++) begin
                    s = 128'sd1 <<< 23;
                    for (int k = 0; k < n; k++) begin
                        wt = $signed(q.weight[k]);
                        s = s + wt * v[k][j];
                    end
                    r.data[32*j +: 32] = clamp32(s >>> 24, sat);
                end
                if (sat) r.status = tbe_pkg::STAT_SAT;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [11:0] ca, input logic [11:0] cb,
                           input logic [11:0] cc, input logic [11:0] cd,
                           input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
                           input logic [31:0] wa, input logic [31:0] wb,
                           input logic [31:0] wc, input logic [31:0] wd,
                           input bit typed, input logic [1:0] st);
        query_t q;
        q.cmd = cmd;
        q.corner = '{ca, cb, cc, cd};
        q.point = '{px, py, pz};
        q.weight = '{wa, wb, wc, wd};
        q.typed = typed;
        q.typed_status = st;
        directed.push_back(q);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 4) == 0) return $urandom();
        return $urandom_range(0, 1048575) - 524288;
    endfunction

    function automatic logic [31:0] rand_weight();
        if ($urandom_range(0, 4) == 0) return $urandom();
        return $urandom_range(0, 67108863) - 33554432;
    endfunction

    function automatic logic [11:0] pick(input bit live);
        if (live) return live_written[$urandom_range(0, live_written.size() - 1)];
        return rest_written[$urandom_range(0, rest_written.size() - 1)];
    endfunction

    // Random item: indices of queries always come from written entries.
    function automatic query_t make_random();
        query_t q;
        int     roll;
        roll = $urandom_range(0, 99);
        for (int k = 0; k < 4; k++) q.corner[k] = $urandom();
        for (int j = 0; j < 3; j++) q.point[j] = rand_coord();
        for (int k = 0; k < 4; k++) q.weight[k] = rand_weight();
        q.typed = 1'b0;
        q.typed_status = tbe_pkg::STAT_OK;
        if (roll < 16) q.cmd = tbe_pkg::CMD_WR_REST;
        else if (roll < 30) q.cmd = tbe_pkg::CMD_WR_LIVE;
        else if (roll < 62) q.cmd = tbe_pkg::CMD_TET_BARY;
        else if (roll < 75) q.cmd = tbe_pkg::CMD_TET_LIVE;
        else if (roll < 86) q.cmd = tbe_pkg::CMD_TRI_REST;
        else if (roll < 97) q.cmd = tbe_pkg::CMD_TRI_LIVE;
        else q.cmd = roll[0] ? CMD_SPARE7 : CMD_SPARE6;
        if (q.cmd == tbe_pkg::CMD_TET_BARY || q.cmd == tbe_pkg::CMD_TRI_REST) begin
            for (int k = 0; k < 4; k++) q.corner[k] = pick(1'b0);
            // Now and then repeat a corner to get a degenerate tetrahedron.
            if ($urandom_range(0, 15) == 0) q.corner[2] = q.corner[0];
        end else if (q.cmd == tbe_pkg::CMD_TET_LIVE || q.cmd == tbe_pkg::CMD_TRI_LIVE) begin
            for (int k = 0; k < 4; k++) q.corner[k] = pick(1'b1);
        end
        if (q.cmd == tbe_pkg::CMD_TRI_REST || q.cmd == tbe_pkg::CMD_TRI_LIVE)
            q.corner[3] = $urandom();
        return q;
    endfunction

    // Drive one item, wait for its acceptance and queue its expected result.
    task automatic send_item(input query_t q, input bit calm);
        answer_t a;
        int      gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= q.cmd;
        s_data <= {q.weight[3], q.weight[2], q.weight[1], q.weight[0],
                   q.point[2], q.point[1], q.point[0],
                   q.corner[3], q.corner[2], q.corner[1], q.corner[0]};
        do @(posedge i_clk); while (!s_ready);
        a = predict_embed(q);
        if (q.typed) begin
            a.status = q.typed_status;
            a.data = '0;
        end
        pending.push_back(a);
        if (q.cmd == tbe_pkg::CMD_WR_REST) rest_written.push_back(q.corner[0]);
        if (q.cmd == tbe_pkg::CMD_WR_LIVE) live_written.push_back(q.corner[0]);
    endtask

    // Stimulus: directed table, then random items.
    initial begin
        bit calm;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unit tetrahedron at indices 0..3 and an extreme vertex at the top index.
        add_row(tbe_pkg::CMD_WR_REST, 0, 7, 7, 7, 0, 0, 0, 0, 0, 0, 0, 1, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_WR_REST, 1, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0,
                1, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_WR_REST, 2, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 0,
                1, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_WR_REST, 3, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0,
                1, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_WR_REST, 4095, 4095, 4095, 4095, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, '1, '1, '1, '1, 1, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_WR_LIVE, 0, 0, 0, 0, 32'h20000, 32'hFFFF0000, 0, 0, 0, 0, 0,
                1, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_WR_LIVE, 1, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000,
                0, 0, 0, 0, 1, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_WR_LIVE, 2, 0, 0, 0, 0, 32'h30000, 32'hFFFE0000, 0, 0, 0, 0,
                1, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_WR_LIVE, 3, 0, 0, 0, 32'h8000, 0, 32'h10000, 0, 0, 0, 0,
                1, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_WR_LIVE, 4095, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 0, 0, 0, 0, 1, tbe_pkg::STAT_OK);
        // Barycentric queries: inside point, degenerate, saturating, extreme corner.
        add_row(tbe_pkg::CMD_TET_BARY, 0, 1, 2, 3, 32'h4000, 32'h4000, 32'h4000,
                0, 0, 0, 0, 0, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_TET_BARY, 0, 0, 2, 3, 32'h4000, 32'h4000, 32'h4000,
                0, 0, 0, 0, 1, tbe_pkg::STAT_DEGEN);
        add_row(tbe_pkg::CMD_TET_BARY, 0, 1, 2, 3, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                0, 0, 0, 0, 0, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_TET_BARY, 4095, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0,
                0, tbe_pkg::STAT_OK);
        // Blends with extreme and ordinary weights.
        add_row(tbe_pkg::CMD_TET_LIVE, 0, 1, 2, 4095, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000, 0, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_TET_LIVE, 0, 1, 2, 3, 0, 0, 0, 32'h400000, 32'h400000,
                32'h400000, 32'h400000, 0, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_TRI_REST, 1, 2, 3, 0, 0, 0, 0, 32'h555555, 32'h555555,
                32'h555556, 32'h7FFFFFFF, 0, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_TRI_REST, 4095, 4095, 4095, 4095, 0, 0, 0, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_TRI_LIVE, 0, 1, 2, 4095, 0, 0, 0, 32'h1000000, 32'hFF800000,
                32'h800000, 32'h12345678, 0, tbe_pkg::STAT_OK);
        add_row(tbe_pkg::CMD_TRI_LIVE, 4095, 0, 4095, 0, 0, 0, 0, 32'h80000000,
                32'h80000000, 32'h80000000, 0, 0, tbe_pkg::STAT_OK);
        // Unknown commands leave everything unchanged and return zeros.
        add_row(CMD_SPARE6, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1, tbe_pkg::STAT_OK);
        add_row(CMD_SPARE7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, tbe_pkg::STAT_OK);

        calm = 1'b0;
        foreach (directed[i]) send_item(directed[i], calm);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 39) == 0) calm = !calm;
            send_item(make_random(), calm);
        end
        s_valid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (pending.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        stim_done = 1'b1;
    end

    // Receiver: random stalls per item, checks each accepted result.
    initial begin
        answer_t want;
        int      stall;
        bit      calm;
        calm = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(m_valid && m_ready));
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result with nothing pending: status %0d data %h",
                                           m_user, m_data);
            end else begin
                want = pending.pop_front();
                if (m_user !== want.status) begin
                    errors++;
                    if (errors <= 10) $display("status: expected %0d, got %0d",
                                               want.status, m_user);
                end
                for (int k = 0; k < 7; k++) begin
                    if (m_data[32*k +: 32] !== want.data[32*k +: 32]) begin
                        errors++;
                        if (errors <= 10)
                            $display("field %0d: expected %h, got %h", k,
                                     want.data[32*k +: 32], m_data[32*k +: 32]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side, and the verdict.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (stim_done) begin
                errors += pending.size();
                if (errors == 0) $display("DONE: 0 errors");
                else $display("DONE: errors detected");
                $finish;
            end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else if (++quiet >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
